// ===== rtl/thft_pkg.sv =====
// shared types, constants and key hash for the handshake tracker
package thft_pkg;

  localparam int FLOW_SLOTS = 1024;
  localparam int IDX_W = $clog2(FLOW_SLOTS);
  localparam int CNT_W = 11;
  localparam logic [15:0] EXPIRY_RESET = 16'd120;
  localparam logic [63:0] GOLDEN = 64'h0000_0000_9e37_79b9;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_OPENED  = 3'd1,
    EV_SYNACK  = 3'd2,
    EV_DONE    = 3'd3,
    EV_BUSY    = 3'd4,
    EV_SWEEP   = 3'd5
  } event_t;

  // one table entry, valid bit included
  typedef struct packed {
    logic        valid;
    logic [63:0] tag;
    logic [31:0] syn_seq;
    logic [31:0] syn_time;
    logic        synack_present;
    logic [31:0] synack_ack;
    logic [31:0] expiry_stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic [63:0] mix_in(input logic [63:0] seed, input logic [63:0] v);
    mix_in = seed ^ (v + GOLDEN + (seed << 6) + (seed >> 2));
  endfunction

endpackage

// ===== rtl/thft_ram.sv =====
// generic single-port synchronous ram with registered read
module thft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/thft_keygen.sv =====
// registered direction-independent flow key, up to two mixing rounds per step
module thft_keygen (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic [1:0]  step,
  output logic [63:0] key
);
  logic [7:0]  proto;
  logic [15:0] p1, p2;
  logic [63:0] s, s_next;

  always_comb begin
    s_next = s;
    unique case (step)
      2'd0: s_next = thft_pkg::mix_in(thft_pkg::mix_in(64'd0, {32'd0,
                (src_ip <= dst_ip) ? src_ip : dst_ip}), {32'd0,
                (src_ip <= dst_ip) ? dst_ip : src_ip});
      2'd1: s_next = thft_pkg::mix_in(thft_pkg::mix_in(s, {48'd0, p1}), {48'd0, p2});
      2'd2: s_next = thft_pkg::mix_in(s, {56'd0, proto});
      default: s_next = s;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p1 <= (src_ip <= dst_ip) ? src_port : dst_port;
      p2 <= (src_ip <= dst_ip) ? dst_port : src_port;
      proto <= protocol;
    end
    s <= s_next;
  end

  assign key = s;
endmodule

// ===== rtl/tcp_handshake_flow_tracker_unit.sv =====
// top level: handshake tracker with a direct-mapped flow table in one ram
// Usage: in_valid/in_ready carry one request (packet or sweep tick when mode
// is 1); out_valid/out_ready return exactly one result per request, in
// order. cfg_valid/cfg_ready write the expiry value and are always ready.
// A packet is hashed in the accept cycle, S_H1 and S_H2 (up to two mixing
// rounds each), S_RD reads the slot, and the S_UPD edge writes the slot
// and the result. Only then is the next request taken.
// The table ram has one port; a packet is one read and at most one write.
// A sweep tick walks every slot of the table through S_SRD, S_SWAIT and
// S_SUPD in turn: read, wait, then write-back.
// After reset a clearing pass writes every slot invalid, during which no
// request is accepted; configuration writes still are.
// One request is in flight at a time. The result sits in an output
// register; while out_ready is low the next request is already accepted
// and processed; a packet then waits before writeback until it is free.
module tcp_handshake_flow_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] src_ip,
  input  logic [31:0] dst_ip,
  input  logic [15:0] src_port,
  input  logic [15:0] dst_port,
  input  logic [7:0]  protocol,
  input  logic        syn_flag,
  input  logic        ack_flag,
  input  logic [31:0] seq_num,
  input  logic [31:0] ack_num,
  input  logic [31:0] capture_sec,
  input  logic [31:0] now_sec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [63:0] flow_key,
  output logic [31:0] syn_seq,
  output logic [31:0] synack_ack,
  output logic [31:0] final_ack_seq,
  output logic [31:0] syn_time,
  output logic [10:0] expired_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  localparam int IW = thft_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_H1, S_H2, S_RD, S_UPD, S_SRD, S_SWAIT, S_SUPD, S_DONE
  } state_t;

  state_t state;
  logic [15:0] expiry;
  logic        r_syn, r_ack;
  logic [31:0] r_seq, r_ackn, r_cap, r_now;
  logic [IW-1:0] idx;
  logic [IW:0]   sweep_i;
  logic [thft_pkg::CNT_W-1:0] cnt;
  logic [1:0]  hstep;
  logic [63:0] key;
  logic        ram_we;
  logic [IW-1:0] ram_addr;
  thft_pkg::entry_t ram_wd, ram_rd, upd;
  logic [2:0]  ev;
  logic        upd_we;
  logic [32:0] lim, win;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);

  thft_keygen u_key (
    .clk(clk), .start(in_valid && in_ready), .src_ip(src_ip), .dst_ip(dst_ip),
    .src_port(src_port), .dst_port(dst_port), .protocol(protocol),
    .step(hstep), .key(key)
  );

  thft_ram #(.WIDTH(thft_pkg::ENTRY_W), .DEPTH(thft_pkg::FLOW_SLOTS)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  always_comb begin
    hstep = 2'd3;
    unique case (state)
      S_IDLE:  hstep = 2'd0;
      S_H1:    hstep = 2'd1;
      S_H2:    hstep = 2'd2;
      default: hstep = 2'd3;
    endcase
  end

  // packet decision on the read entry
  always_comb begin
    logic hit;
    hit = ram_rd.valid && (ram_rd.tag == key);
    upd = ram_rd;
    upd_we = 1'b0;
    ev = thft_pkg::EV_IGNORED;
    win = {1'b0, ram_rd.syn_time} + {17'd0, expiry};
    if (hit) begin
      if (r_syn && r_ack && !ram_rd.synack_present && (ram_rd.syn_seq + 32'd1 == r_ackn)) begin
        upd.synack_ack = r_ackn;
        upd.synack_present = 1'b1;
        upd.expiry_stamp = r_now;
        upd_we = 1'b1;
        ev = thft_pkg::EV_SYNACK;
      end else if (!r_syn && r_ack && ram_rd.synack_present && ram_rd.synack_ack == r_seq) begin
        upd_we = 1'b1;
        upd.expiry_stamp = r_now;
        if (win > {1'b0, r_now}) begin
          upd.expiry_stamp = r_now - {16'd0, expiry};
          ev = thft_pkg::EV_DONE;
        end
      end
    end else if (r_syn && !r_ack) begin
      if (ram_rd.valid) begin
        ev = thft_pkg::EV_BUSY;
      end else begin
        upd = '{valid: 1'b1, tag: key, syn_seq: r_seq, syn_time: r_cap,
                synack_present: 1'b0, synack_ack: 32'd0, expiry_stamp: r_cap};
        upd_we = 1'b1;
        ev = thft_pkg::EV_OPENED;
      end
    end
  end

  assign lim = {1'b0, r_now} - {17'd0, expiry};

  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx;
    ram_wd = ram_rd;
    unique case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_addr = sweep_i[IW-1:0];
        ram_wd = '0;
      end
      S_RD:    ram_addr = key[IW-1:0];
      S_UPD: begin
        ram_we = upd_we && !out_valid;
        ram_wd = upd;
      end
      S_SRD, S_SWAIT: ram_addr = sweep_i[IW-1:0];
      S_SUPD: begin
        ram_addr = sweep_i[IW-1:0];
        ram_we = 1'b1;
        ram_wd = ram_rd;
        ram_wd.valid = ram_rd.valid && !(!lim[32] && {1'b0, ram_rd.expiry_stamp} < lim);
      end
      default: ram_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sweep_i <= '0;
      expiry <= thft_pkg::EXPIRY_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        expiry <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          sweep_i <= sweep_i + 1'b1;
          if (sweep_i == (IW+1)'(thft_pkg::FLOW_SLOTS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            r_syn <= syn_flag; r_ack <= ack_flag;
            r_seq <= seq_num; r_ackn <= ack_num; r_cap <= capture_sec; r_now <= now_sec;
            sweep_i <= '0;
            cnt <= '0;
            state <= mode ? S_SRD : S_H1;
          end
        end
        S_H1: state <= S_H2;
        S_H2: state <= S_RD;
        S_RD: begin
          idx <= key[IW-1:0];
          state <= S_UPD;
        end
        S_UPD: begin
          if (!out_valid) begin
            event_res <= ev;
            flow_key <= key;
            syn_seq <= (ev == thft_pkg::EV_DONE) ? ram_rd.syn_seq : 32'd0;
            synack_ack <= (ev == thft_pkg::EV_DONE) ? ram_rd.synack_ack : 32'd0;
            final_ack_seq <= (ev == thft_pkg::EV_DONE) ? r_seq : 32'd0;
            syn_time <= (ev == thft_pkg::EV_DONE) ? ram_rd.syn_time : 32'd0;
            expired_count <= '0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SRD: state <= S_SWAIT;
        S_SWAIT: state <= S_SUPD;
        S_SUPD: begin
          if (ram_rd.valid && !lim[32] && {1'b0, ram_rd.expiry_stamp} < lim
              && cnt != thft_pkg::CNT_MAX) begin
            cnt <= cnt + 1'b1;
          end
          if (sweep_i == (IW+1)'(thft_pkg::FLOW_SLOTS - 1)) begin
            state <= S_DONE;
          end else begin
            sweep_i <= sweep_i + 1'b1;
            state <= S_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            event_res <= thft_pkg::EV_SWEEP;
            flow_key <= '0;
            syn_seq <= '0; synack_ack <= '0; final_ack_seq <= '0; syn_time <= '0;
            expired_count <= cnt;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== test/tb_tcp_handshake_flow_tracker_unit.sv =====
// testbench for the handshake tracker: directed and random requests against a table model
module tb_tcp_handshake_flow_tracker_unit;

  typedef struct {
    bit        mode;
    bit [31:0] sip, dip;
    bit [15:0] sp, dp;
    bit [7:0]  proto;
    bit        syn, ack;
    bit [31:0] seq, ackn, cap, now;
  } request_t;

  typedef struct {
    thft_pkg::event_t ev;
    logic [63:0] key;
    logic [31:0] sseq, sack, fack, stime;
    logic [10:0] cnt;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic [31:0] src_ip = '0, dst_ip = '0;
  logic [15:0] src_port = '0, dst_port = '0;
  logic [7:0] protocol = '0;
  logic syn_flag = 1'b0, ack_flag = 1'b0;
  logic [31:0] seq_num = '0, ack_num = '0, capture_sec = '0, now_sec = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] event_res;
  logic [63:0] flow_key;
  logic [31:0] syn_seq, synack_ack, final_ack_seq, syn_time;
  logic [10:0] expired_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_data = '0;

  tcp_handshake_flow_tracker_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .src_ip(src_ip), .dst_ip(dst_ip), .src_port(src_port), .dst_port(dst_port),
    .protocol(protocol), .syn_flag(syn_flag), .ack_flag(ack_flag),
    .seq_num(seq_num), .ack_num(ack_num), .capture_sec(capture_sec), .now_sec(now_sec),
    .out_valid(out_valid), .out_ready(out_ready), .event_res(event_res),
    .flow_key(flow_key), .syn_seq(syn_seq), .synack_ack(synack_ack),
    .final_ack_seq(final_ack_seq), .syn_time(syn_time), .expired_count(expired_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // local copy of the flow table
  bit [15:0] lifetime;
  bit        tb_valid [thft_pkg::FLOW_SLOTS];
  bit [63:0] tb_tag [thft_pkg::FLOW_SLOTS];
  bit [31:0] tb_syn_seq [thft_pkg::FLOW_SLOTS];
  bit [31:0] tb_syn_time [thft_pkg::FLOW_SLOTS];
  bit        tb_synack [thft_pkg::FLOW_SLOTS];
  bit [31:0] tb_synack_ack [thft_pkg::FLOW_SLOTS];
  bit [31:0] tb_stamp [thft_pkg::FLOW_SLOTS];

  outcome_t pending_outcomes[$];
  int errors = 0;
  int requests_sent = 0;
  int completions = 0;
  int sweeps = 0;
  int busy_seen = 0;
  int hold_left = 0;
  bit [31:0] wall = 32'd1000;

  function automatic bit [63:0] fold(bit [63:0] s, bit [63:0] v);
    return s ^ (v + thft_pkg::GOLDEN + (s << 6) + (s >> 2));
  endfunction

  // endpoints ordered by address so both directions share a key
  function automatic bit [63:0] flow_hash(request_t r);
    bit [63:0] s;
    s = 64'd0;
    if (r.sip <= r.dip) begin
      s = fold(s, r.sip);
      s = fold(s, r.dip);
      s = fold(s, r.sp);
      s = fold(s, r.dp);
    end else begin
      s = fold(s, r.dip);
      s = fold(s, r.sip);
      s = fold(s, r.dp);
      s = fold(s, r.sp);
    end
    return fold(s, r.proto);
  endfunction

  function automatic outcome_t tracker_outcome(request_t r);
    outcome_t o;
    bit [63:0] key;
    int idx;
    bit hit;
    bit [32:0] limit;
    o = '{thft_pkg::EV_IGNORED, 64'd0, 32'd0, 32'd0, 32'd0, 32'd0, 11'd0};
    if (r.mode) begin
      o.ev = thft_pkg::EV_SWEEP;
      if (r.now >= lifetime) begin
        limit = {1'b0, r.now} - lifetime;
        for (int i = 0; i < thft_pkg::FLOW_SLOTS; i++) begin
          if (tb_valid[i] && {1'b0, tb_stamp[i]} < limit) begin
            tb_valid[i] = 1'b0;
            if (o.cnt != thft_pkg::CNT_MAX) o.cnt++;
          end
        end
      end
      return o;
    end
    key = flow_hash(r);
    idx = int'(key % thft_pkg::FLOW_SLOTS);
    hit = tb_valid[idx] && tb_tag[idx] == key;
    o.key = key;
    if (hit) begin
      if (r.syn && r.ack && !tb_synack[idx] && tb_syn_seq[idx] + 32'd1 == r.ackn) begin
        tb_synack_ack[idx] = r.ackn;
        tb_synack[idx] = 1'b1;
        tb_stamp[idx] = r.now;
        o.ev = thft_pkg::EV_SYNACK;
      end else if (!r.syn && r.ack && tb_synack[idx] && tb_synack_ack[idx] == r.seq) begin
        tb_stamp[idx] = r.now;
        if ({1'b0, tb_syn_time[idx]} + lifetime > {1'b0, r.now}) begin
          tb_stamp[idx] = r.now - lifetime;
          o.ev = thft_pkg::EV_DONE;
          o.sseq = tb_syn_seq[idx];
          o.sack = tb_synack_ack[idx];
          o.fack = r.seq;
          o.stime = tb_syn_time[idx];
        end
      end
    end else if (r.syn && !r.ack) begin
      if (tb_valid[idx]) begin
        o.ev = thft_pkg::EV_BUSY;
      end else begin
        tb_valid[idx] = 1'b1;
        tb_tag[idx] = key;
        tb_syn_seq[idx] = r.seq;
        tb_syn_time[idx] = r.cap;
        tb_synack[idx] = 1'b0;
        tb_synack_ack[idx] = 32'd0;
        tb_stamp[idx] = r.cap;
        o.ev = thft_pkg::EV_OPENED;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    outcome_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", event_res, 0);
      end else begin
        w = pending_outcomes.pop_front();
        if (event_res !== w.ev) report_mismatch("event_res", event_res, w.ev);
        if (flow_key !== w.key) report_mismatch("flow_key", flow_key, w.key);
        if (syn_seq !== w.sseq) report_mismatch("syn_seq", syn_seq, w.sseq);
        if (synack_ack !== w.sack) report_mismatch("synack_ack", synack_ack, w.sack);
        if (final_ack_seq !== w.fack) report_mismatch("final_ack_seq", final_ack_seq, w.fack);
        if (syn_time !== w.stime) report_mismatch("syn_time", syn_time, w.stime);
        if (expired_count !== w.cnt) report_mismatch("expired_count", expired_count, w.cnt);
        if (w.ev == thft_pkg::EV_DONE) completions++;
        if (w.ev == thft_pkg::EV_BUSY) busy_seen++;
      end
    end
  end

  // receiver stall pattern, with a long hold-off when a test sets hold_left
  initial begin
    bit [7:0] pattern;
    int cyc;
    pattern = 8'hff;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 50 == 0)
        pattern = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = pattern[cyc % 8];
      end
    end
  end

  task automatic send_request(request_t r);
    @(negedge clk);
    in_valid = 1'b1;
    mode = r.mode;
    src_ip = r.sip; dst_ip = r.dip;
    src_port = r.sp; dst_port = r.dp;
    protocol = r.proto;
    syn_flag = r.syn; ack_flag = r.ack;
    seq_num = r.seq; ack_num = r.ackn;
    capture_sec = r.cap; now_sec = r.now;
    do @(posedge clk); while (!in_ready);
    pending_outcomes.push_back(tracker_outcome(r));
    requests_sent++;
    if (r.mode) sweeps++;
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_lifetime(bit [15:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    lifetime = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic request_t packet(bit [31:0] sip, bit [31:0] dip, bit [15:0] sp,
                                      bit [15:0] dp, bit [7:0] proto, bit syn, bit ack,
                                      bit [31:0] seq, bit [31:0] ackn, bit [31:0] cap,
                                      bit [31:0] now);
    request_t r;
    r = '{1'b0, sip, dip, sp, dp, proto, syn, ack, seq, ackn, cap, now};
    return r;
  endfunction

  function automatic request_t sweep_tick(bit [31:0] now);
    request_t r;
    r = packet($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, now);
    r.mode = 1'b1;
    return r;
  endfunction

  function automatic request_t noise();
    request_t r;
    r = packet($urandom, $urandom, 16'($urandom), 16'($urandom), 8'($urandom),
               1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom);
    return r;
  endfunction

  task automatic test_directed();
    request_t c;
    bit [63:0] k;
    write_lifetime(16'd100);
    // full handshake, reply seen from the other direction
    send_request(packet(32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 8'hff, 1, 0,
                        32'hffff_ffff, 32'h0, 32'd500, 32'd500));
    send_request(packet(32'h0, 32'hffff_ffff, 16'h0, 16'hffff, 8'hff, 1, 1,
                        32'h1234, 32'h0, 32'd501, 32'd501));
    send_request(packet(32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 8'hff, 0, 1,
                        32'h0, 32'h1235, 32'd502, 32'd502));
    // repeated ack still inside the window completes again
    send_request(packet(32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 8'hff, 0, 1,
                        32'h0, 32'h1235, 32'd503, 32'd503));
    // ack after the window: stamp refreshed, no completion
    send_request(packet(32'hffff_ffff, 32'h0, 16'hffff, 16'h0, 8'hff, 0, 1,
                        32'h0, 32'h1235, 32'd700, 32'd700));
    // second flow: duplicate syn, wrong synack, right synack, wrong ack
    send_request(packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 1, 0,
                        32'd10, 32'd0, 32'd600, 32'd600));
    send_request(packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 1, 0,
                        32'd77, 32'd0, 32'd600, 32'd600));
    send_request(packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 1, 1,
                        32'd5, 32'd12, 32'd601, 32'd601));
    send_request(packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 1, 1,
                        32'd5, 32'd11, 32'd601, 32'd601));
    send_request(packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 0, 1,
                        32'd99, 32'd0, 32'd602, 32'd602));
    // packet with no entry that is not a pure syn
    send_request(packet(32'h1, 32'h2, 16'd3, 16'd4, 8'd17, 0, 1, 32'd1, 32'd1, 32'd1, 32'd1));
    send_request(packet(32'h1, 32'h2, 16'd3, 16'd4, 8'd17, 0, 0, 32'd1, 32'd1, 32'd1, 32'd1));
    // different tag on an occupied slot
    c = packet(32'h0a00_0001, 32'h0a00_0001, 16'd80, 16'd80, 8'd6, 1, 0, 0, 0, 650, 650);
    k = flow_hash(c);
    do begin
      c.sip = $urandom;
      c.sp = 16'($urandom);
    end while (flow_hash(c) % thft_pkg::FLOW_SLOTS != k % thft_pkg::FLOW_SLOTS
               || flow_hash(c) == k);
    send_request(c);
    // sweep with now below the lifetime removes nothing, then sweeps at 650 and at the time extremes
    send_request(sweep_tick(32'd5));
    send_request(sweep_tick(32'd650));
    send_request(sweep_tick(32'hffff_ffff));
    send_request(packet(32'h5, 32'h6, 16'd1, 16'd2, 8'd6, 1, 0, 32'h0, 32'd0,
                        32'hffff_ff90, 32'hffff_ff90));
    send_request(packet(32'h6, 32'h5, 16'd2, 16'd1, 8'd6, 1, 1, 32'h0, 32'd1,
                        32'hffff_ffa0, 32'hffff_ffa0));
    send_request(packet(32'h5, 32'h6, 16'd1, 16'd2, 8'd6, 0, 1, 32'd1, 32'd0,
                        32'hffff_ffb0, 32'hffff_ffb0));
    send_request(sweep_tick(32'd0));
  endtask

  // client is side a of each pooled flow
  bit [31:0] fa [64], fb [64], fseq [64], fack [64];
  bit [15:0] fpa [64], fpb [64];
  bit [7:0]  fproto [64];
  int        fstage [64];

  task automatic advance_flow(int f);
    request_t r;
    case (fstage[f])
      0: begin
        if (fa[f] == 0 || $urandom_range(0, 1)) begin
          fa[f] = $urandom;
          fb[f] = ($urandom_range(0, 19) == 0) ? fa[f] : $urandom;
          fpa[f] = 16'($urandom);
          fpb[f] = 16'($urandom);
          fproto[f] = 8'($urandom);
        end
        fseq[f] = $urandom;
        r = packet(fa[f], fb[f], fpa[f], fpb[f], fproto[f], 1, 0, fseq[f], $urandom,
                   wall, wall);
        fstage[f] = 1;
      end
      1: begin
        fack[f] = fseq[f] + (($urandom_range(0, 9) == 0) ? 32'd2 : 32'd1);
        r = packet(fb[f], fa[f], fpb[f], fpa[f], fproto[f], 1, 1, $urandom, fack[f],
                   wall, wall);
        fstage[f] = 2;
      end
      default: begin
        r = packet(fa[f], fb[f], fpa[f], fpb[f], fproto[f], 0, 1,
                   ($urandom_range(0, 9) == 0) ? $urandom : fack[f], $urandom, wall, wall);
        fstage[f] = ($urandom_range(0, 3) == 0) ? 2 : 0;
      end
    endcase
    send_request(r);
  endtask

  task automatic test_random_phase(bit [15:0] life, int count);
    int burst;
    int pick;
    write_lifetime(life);
    burst = $urandom_range(1, 20);
    for (int n = 0; n < count; n++) begin
      wall += $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) wall += $urandom_range(0, 300);
      pick = $urandom_range(0, 99);
      if (pick < 72) advance_flow($urandom_range(0, 63));
      else if (pick < 75) send_request(sweep_tick(wall));
      else send_request(noise());
      burst--;
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
        burst = $urandom_range(1, 20);
      end
    end
  endtask

  task automatic test_backpressure();
    drain();
    hold_left = 400;
    for (int n = 0; n < 12; n++) begin
      wall += 1;
      advance_flow($urandom_range(0, 63));
    end
    drain();
  endtask

  initial begin
    lifetime = thft_pkg::EXPIRY_RESET;
    foreach (fstage[i]) fstage[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_phase(16'd120, 300);
    test_backpressure();
    test_random_phase(16'd0, 300);
    test_random_phase(16'hffff, 300);
    test_random_phase(16'd30, 350);
    test_random_phase(16'd7, 350);
    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d requests, %0d sweeps, %0d completed handshakes, %0d busy slots",
             requests_sent, sweeps, completions, busy_seen);
    $display("errors %0d, results outstanding %0d", errors, pending_outcomes.size());
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("tb_tcp_handshake_flow_tracker_unit OK");
    end else begin
      $display("tb_tcp_handshake_flow_tracker_unit NOT OK");
    end
    $finish;
  end

  initial begin
    #200_000_000;
    $display("timeout");
    $display("tb_tcp_handshake_flow_tracker_unit NOT OK");
    $finish;
  end

endmodule

// ===== tcp_handshake_flow_tracker_unit.f =====
rtl/thft_pkg.sv
rtl/thft_ram.sv
rtl/thft_keygen.sv
rtl/tcp_handshake_flow_tracker_unit.sv
test/tb_tcp_handshake_flow_tracker_unit.sv
